// ===== rtl/core/fijs_pkg.sv =====
// Package for the frame interval jitter statistics block.
// Widths, the sequencer state type and shared constants. No dependencies.
`default_nettype none
package fijs_pkg;
   localparam int TIME_W  = 63;
   localparam int STAT_W  = 32;
   localparam int MEAN_W  = 40;
   localparam int SSQ_W   = 64;
   localparam int FRAC_W  = 8;
   localparam int DEFAULT_DIGIT_W = 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SUB   = 7'b0000010,
      ST_DIV1  = 7'b0000100,
      ST_MUL   = 7'b0001000,
      ST_DIV2  = 7'b0010000,
      ST_SQRT  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/core/fijs_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface fijs_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/fijs_divider.sv =====
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on nothing.
`default_nettype none
module fijs_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             busy,
   output logic [63:0]      quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [32:0] trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff[31:0], quo_ff[63]} - {1'b0, divisor};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         if (!trial[32] || rem_ff[31]) begin
            rem_in = {1'b0, trial[31:0]};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy     = (cnt_ff != 7'd0) || start;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

// ===== rtl/core/fijs_multiplier.sv =====
// Shift-add multiplier, 64 x 64 -> 128, one multiplier digit per cycle.
// Depends on fijs_pkg.
`default_nettype none
module fijs_multiplier #(
   parameter int DIGIT_W = fijs_pkg::DEFAULT_DIGIT_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [63:0]  mcand,
   input  wire logic [63:0]  mplier,
   output logic              busy,
   output logic [127:0]      product
);
   localparam int STEPS = 64 / DIGIT_W;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  mc_ff, mc_in;
   logic [63:0]  mp_ff, mp_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63+DIGIT_W:0] part;

   // accumulate high part, shift product right by one digit per step
   always_comb begin
      acc_in = acc_ff;
      mc_in  = mc_ff;
      mp_in  = mp_ff;
      cnt_in = cnt_ff;
      part   = (64+DIGIT_W)'(acc_ff[127:64]) +
               (64+DIGIT_W)'(mc_ff * mp_ff[DIGIT_W-1:0]);
      if (start) begin
         acc_in = '0;
         mc_in  = mcand;
         mp_in  = mplier;
         cnt_in = 7'(STEPS);
      end else if (cnt_ff != 7'd0) begin
         cnt_in = cnt_ff - 7'd1;
         acc_in = 128'({part, acc_ff[63:0]} >> DIGIT_W);
         mp_in  = mp_ff >> DIGIT_W;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy    = (cnt_ff != 7'd0) || start;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ===== rtl/core/fijs_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// Depends on nothing.
`default_nettype none
module fijs_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             busy,
   output logic [31:0]      root
);
   logic [63:0] val_ff, val_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [33:0] shifted, trial;

   // remainder takes two bits per step; subtract 4*root+1
   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      shifted = {rem_ff[31:0], val_ff[63:62]};
      trial   = shifted - {root_ff, 2'b01};
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         cnt_in = cnt_ff - 6'd1;
         val_in = {val_ff[61:0], 2'b00};
         if (!trial[33] && !(rem_ff[33] || rem_ff[32])) begin
            rem_in  = trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy = (cnt_ff != 6'd0) || start;
   assign root = root_ff;
endmodule
`default_nettype wire

// ===== rtl/core/frame_interval_jitter_stats.sv =====
// Frame interval jitter statistics, top level: sequencer, state and result register.
// Depends on fijs_pkg, fijs_if, fijs_divider, fijs_multiplier, fijs_sqrt.
//
// Use: one beat on the req_ channel carries a 63-bit frame arrival time in
// ns. Each beat yields exactly one rsp_ beat with the frame count, mean
// interval, jitter (population standard deviation), min and max interval
// and a valid flag. The first frame after reset only stores its time.
// Sequence: a setup step starts a serial divide for the mean, then come a
// serial multiply, a second serial divide for M2/n, a serial square root and
// a load into the output register.
// With fewer than two intervals the second divide and the root are skipped;
// the first frame goes straight from idle to the load.
// Throughput: one item at a time; req_ready is low from acceptance until the
// result has been loaded, and comes back as it is loaded.
// The output register holds the result until rsp_ready; while it is full
// and unaccepted no new result is loaded, so a stalled receiver stalls the
// block. A new beat may be accepted while the previous result still waits.
// Reset (synchronous, active high) clears all statistics and the control.
`default_nettype none
module frame_interval_jitter_stats #(
   parameter int DIGIT_W = fijs_pkg::DEFAULT_DIGIT_W
) (
   input wire logic clock,
   input wire logic reset,
   fijs_if.sink     req,
   fijs_if.source   rsp
);
   // payload: req.data.frame_time_ns, rsp.data.{frames_seen ... stats_valid}
   fijs_pkg::state_type state_ff, state_in;

   logic        have_prev_ff;
   logic [62:0] last_time_ff;
   logic [31:0] count_ff;
   logic [39:0] mean_ff;
   logic [63:0] ssq_ff;
   logic [31:0] min_ff, max_ff;
   logic [39:0] xf_ff;
   logic [40:0] delta_ff;   // signed
   logic [31:0] n_ff;
   logic [31:0] jit_ff;
   logic        rsp_valid_ff;

   logic        div_start, mul_start, sq_start;
   logic        div_busy, mul_busy, sq_busy;
   logic [63:0] div_a;
   logic [31:0] div_b;
   logic [63:0] div_q;
   logic [127:0] prod;
   logic [31:0] root;
   logic [63:0] diff;
   logic [31:0] x;
   logic [39:0] mean_new;
   logic [40:0] d2;
   logic [40:0] delta_abs, d2_abs;
   logic [63:0] adda;
   logic [64:0] ssum;
   logic [63:0] ssq_next;
   logic        div_first;

   fijs_divider u_div (.clock, .reset, .start(div_start), .dividend(div_a),
                       .divisor(div_b), .busy(div_busy), .quotient(div_q));
   fijs_multiplier #(.DIGIT_W(DIGIT_W)) u_mul (.clock, .reset, .start(mul_start),
      .mcand({23'd0, delta_abs}),
      .mplier({23'd0, d2_abs}), .busy(mul_busy), .product(prod));
   fijs_sqrt u_sq (.clock, .reset, .start(sq_start), .radicand(div_q),
                   .busy(sq_busy), .root(root));

   assign req.ready = (state_ff == fijs_pkg::ST_IDLE);

   // interval with clamp
   assign diff = ({1'b0, req.data.frame_time_ns} >= {1'b0, last_time_ff}) ?
                 64'(req.data.frame_time_ns) - 64'(last_time_ff) : 64'd0;
   assign x    = (diff[63:32] != '0) ? '1 : diff[31:0];

   // mean update: |delta|/n with sign restored
   assign div_first = (state_ff == fijs_pkg::ST_SUB);
   assign delta_abs = delta_ff[40] ? -delta_ff : delta_ff;
   assign div_a = div_first ? {23'd0, delta_abs} : ssq_next;
   assign div_b = n_ff;
   assign mean_new = delta_ff[40] ? mean_ff - div_q[39:0] : mean_ff + div_q[39:0];
   // second factor uses the updated mean
   assign d2 = {1'b0, xf_ff} - {1'b0, mean_new};
   assign d2_abs = d2[40] ? -d2 : d2;
   assign adda = (prod[127:80] != '0) ? '1 : prod[79:16];
   assign ssum = {1'b0, ssq_ff} + {1'b0, adda};
   assign ssq_next = ssum[64] ? '1 : ssum[63:0];

   assign div_start = div_first ||
                      (state_ff == fijs_pkg::ST_MUL && !mul_busy && n_ff >= 32'd2);
   assign mul_start = (state_ff == fijs_pkg::ST_DIV1 && !div_busy);
   assign sq_start  = (state_ff == fijs_pkg::ST_DIV2 && !div_busy);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fijs_pkg::ST_IDLE:
            if (req.valid) state_in = have_prev_ff ? fijs_pkg::ST_SUB : fijs_pkg::ST_OUT;
         fijs_pkg::ST_SUB:  state_in = fijs_pkg::ST_DIV1;
         fijs_pkg::ST_DIV1: if (!div_busy) state_in = fijs_pkg::ST_MUL;
         fijs_pkg::ST_MUL:
            if (!mul_busy) state_in = (n_ff >= 32'd2) ? fijs_pkg::ST_DIV2 : fijs_pkg::ST_OUT;
         fijs_pkg::ST_DIV2: if (!div_busy) state_in = fijs_pkg::ST_SQRT;
         fijs_pkg::ST_SQRT: if (!sq_busy) state_in = fijs_pkg::ST_OUT;
         fijs_pkg::ST_OUT:  if (!rsp_valid_ff || rsp.ready) state_in = fijs_pkg::ST_IDLE;
         default: state_in = fijs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fijs_pkg::ST_IDLE;
         have_prev_ff <= 1'b0;
         last_time_ff <= '0;
         count_ff     <= '0;
         mean_ff      <= '0;
         ssq_ff       <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         jit_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == fijs_pkg::ST_OUT && (!rsp_valid_ff || rsp.ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready)
            rsp_valid_ff <= 1'b0;
         if (state_ff == fijs_pkg::ST_IDLE && req.valid) begin
            last_time_ff <= req.data.frame_time_ns;
            jit_ff       <= '0;
            if (!have_prev_ff) begin
               have_prev_ff <= 1'b1;
               count_ff     <= 32'd1;
            end else begin
               if (count_ff != '1) count_ff <= count_ff + 32'd1;
               n_ff     <= (count_ff != '1) ? count_ff : count_ff - 32'd1;
               xf_ff    <= {x, 8'd0};
               delta_ff <= {1'b0, x, 8'd0} - {1'b0, mean_ff};
               if (x < min_ff) min_ff <= x;
               if (x > max_ff) max_ff <= x;
            end
         end
         if (state_ff == fijs_pkg::ST_DIV1 && !div_busy) mean_ff <= mean_new;
         if (state_ff == fijs_pkg::ST_MUL && !mul_busy)
            ssq_ff <= ssq_next;
         if (state_ff == fijs_pkg::ST_SQRT && !sq_busy) jit_ff <= root;
         if (state_ff == fijs_pkg::ST_OUT && (!rsp_valid_ff || rsp.ready)) begin
            rsp.data.frames_seen      <= count_ff;
            rsp.data.mean_interval_ns <= mean_ff[39:8];
            rsp.data.jitter_ns        <= jit_ff;
            rsp.data.min_interval_ns  <= (count_ff >= 32'd2) ? min_ff : '0;
            rsp.data.max_interval_ns  <= (count_ff >= 32'd2) ? max_ff : '0;
            rsp.data.stats_valid      <= (count_ff >= 32'd2);
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;

   // no new beat while busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != fijs_pkg::ST_IDLE) |-> !req.ready) else $error("ready while busy");
   // count never drops
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> count_ff >= $past(count_ff)) else $error("count dropped");
   // min not above max once valid
   a_mm: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= 32'd2) |-> min_ff <= max_ff) else $error("min above max");
endmodule
`default_nettype wire
